// ===== sv/gef_pkg.sv =====
package gef_pkg;

    localparam int PIN_CHANNEL_MAX = 27;
    localparam int PIN_W = PIN_CHANNEL_MAX + 1;
    localparam int PIN_IDX_W = (PIN_W > 1) ? $clog2(PIN_W) : 1;
    localparam logic [7:0] RENDER_CHANNEL_MAX = 8'd255;
    localparam logic [7:0] LABEL_LEN_MAX = 8'd127;

    localparam int WORD_W = 32;
    localparam int DELTA_W = 24;
    localparam int REQ_W = 4;

    localparam logic [WORD_W-1:0] STATE_MASK = 32'h0fff_ffff;
    localparam logic [WORD_W-1:0] SYNC_WORD = 32'hA55A_AA55;
    localparam logic [7:0] HDR_LOW = 8'h00;
    localparam logic [7:0] HDR_HIGH = 8'h20;
    localparam logic [7:0] HDR_LABEL = 8'h80;
    localparam logic [7:0] HDR_SYNC = 8'hA0;
    localparam logic [7:0] HDR_HEX = 8'hC0;
    localparam logic [7:0] HDR_ASCII = 8'hE0;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [REQ_W-1:0] {
        REQ_HIGH    = 4'd0,
        REQ_LOW     = 4'd1,
        REQ_TOGGLE  = 4'd2,
        REQ_SYNC    = 4'd3,
        REQ_LABEL   = 4'd4,
        REQ_TEXT    = 4'd5,
        REQ_PAYLOAD = 4'd6,
        REQ_START   = 4'd7,
        REQ_TIMER   = 4'd8
    } req_t;

    typedef enum logic [1:0] {
        ENT_ONE  = 2'd0,
        ENT_TWO  = 2'd1,
        ENT_SYNC = 2'd2
    } ent_kind_t;

    typedef struct packed {
        ent_kind_t         kind;
        logic              end0;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
    } entry_t;

endpackage

// ===== sv/gef_front.sv =====
module gef_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic [gef_pkg::REQ_W-1:0]    req_type,
    input  logic [gef_pkg::WORD_W-1:0]   tick_now,
    input  logic [7:0]                   channel,
    input  logic                         text_mode,
    input  logic [7:0]                   frame_len,
    input  logic [7:0]                   payload_byte,
    output logic                         push,
    output gef_pkg::entry_t              entry
);
    import gef_pkg::*;

    logic [PIN_W-1:0]  pin_levels_reg, pin_levels_next;
    logic [WORD_W-1:0] last_tick_reg, last_tick_next;
    logic              started_reg, started_next;
    logic              collecting_reg, collecting_next;
    logic [7:0]        bytes_left_reg, bytes_left_next;
    logic [WORD_W-1:0] pack_word_reg, pack_word_next;
    logic [1:0]        pack_fill_reg, pack_fill_next;

    req_t              req;
    logic [WORD_W-1:0] delta_full;
    logic [DELTA_W-1:0] delta;
    logic [PIN_IDX_W-1:0] pin_idx;
    logic              pin_high;
    logic [7:0]        pin_hdr;
    logic [WORD_W-1:0] pin_state;
    logic [WORD_W-1:0] pack_added;
    logic [1:0]        fill_inc;
    logic [7:0]        left_dec;
    logic [WORD_W-1:0] open_word;
    logic [7:0]        text_hdr;

    always_comb
    begin
        req        = req_t'(req_type);
        delta_full = tick_now - last_tick_reg;
        delta      = delta_full[DELTA_W-1:0];
        pin_idx    = channel[PIN_IDX_W-1:0];
        pin_state  = WORD_W'(pin_levels_reg) & STATE_MASK;
        pack_added = pack_word_reg | (WORD_W'(payload_byte) << {pack_fill_reg, 3'b000});
        fill_inc   = pack_fill_reg + 2'd1;
        left_dec   = bytes_left_reg - 8'd1;
        open_word  = {16'd0, frame_len, channel};
        text_hdr   = text_mode ? HDR_ASCII : HDR_HEX;

        if (req == REQ_HIGH)
        begin
            pin_high = 1'b1;
        end
        else if (req == REQ_LOW)
        begin
            pin_high = 1'b0;
        end
        else
        begin
            pin_high = ~pin_levels_reg[pin_idx];
        end
        pin_hdr = (pin_high ? HDR_HIGH : HDR_LOW) | channel;

        pin_levels_next = pin_levels_reg;
        last_tick_next  = last_tick_reg;
        started_next    = started_reg;
        collecting_next = collecting_reg;
        bytes_left_next = bytes_left_reg;
        pack_word_next  = pack_word_reg;
        pack_fill_next  = pack_fill_reg;
        push            = 1'b0;
        entry.kind      = ENT_ONE;
        entry.end0      = 1'b1;
        entry.w0        = '0;
        entry.w1        = '0;

        if (accept)
        begin
            if (req == REQ_START)
            begin
                pin_levels_next = '0;
                last_tick_next  = tick_now;
                started_next    = 1'b1;
                collecting_next = 1'b0;
                bytes_left_next = '0;
                pack_word_next  = '0;
                pack_fill_next  = '0;
            end
            else if (started_reg && (!collecting_reg || req == REQ_PAYLOAD))
            begin
                unique case (req) inside
                    REQ_HIGH, REQ_LOW, REQ_TOGGLE:
                    begin
                        if (channel <= 8'(PIN_CHANNEL_MAX))
                        begin
                            pin_levels_next[pin_idx] = pin_high;
                            last_tick_next = tick_now;
                            push     = 1'b1;
                            entry.w0 = {pin_hdr, delta};
                        end
                    end
                    REQ_SYNC:
                    begin
                        last_tick_next = tick_now;
                        push       = 1'b1;
                        entry.kind = ENT_SYNC;
                        entry.end0 = 1'b0;
                        entry.w0   = {HDR_SYNC, delta};
                        entry.w1   = pin_state;
                    end
                    REQ_LABEL, REQ_TEXT:
                    begin
                        if (channel <= RENDER_CHANNEL_MAX &&
                            (req == REQ_TEXT || frame_len <= LABEL_LEN_MAX))
                        begin
                            push       = 1'b1;
                            entry.end0 = 1'b0;
                            if (req == REQ_TEXT)
                            begin
                                last_tick_next = tick_now;
                                entry.w0 = {text_hdr, delta};
                            end
                            else
                            begin
                                entry.w0 = {HDR_LABEL, DELTA_W'(0)};
                            end
                            bytes_left_next = frame_len;
                            if (frame_len == 8'd0)
                            begin
                                entry.kind      = ENT_TWO;
                                entry.w1        = open_word;
                                pack_word_next  = '0;
                                pack_fill_next  = '0;
                                collecting_next = 1'b0;
                            end
                            else
                            begin
                                pack_word_next  = open_word;
                                pack_fill_next  = 2'd2;
                                collecting_next = 1'b1;
                            end
                        end
                    end
                    REQ_PAYLOAD:
                    begin
                        if (collecting_reg)
                        begin
                            bytes_left_next = left_dec;
                            if (left_dec == 8'd0 || fill_inc == 2'd0)
                            begin
                                push           = 1'b1;
                                entry.w0       = pack_added;
                                entry.end0     = (left_dec == 8'd0);
                                pack_word_next = '0;
                                pack_fill_next = '0;
                                if (left_dec == 8'd0)
                                begin
                                    collecting_next = 1'b0;
                                end
                            end
                            else
                            begin
                                pack_word_next = pack_added;
                                pack_fill_next = fill_inc;
                            end
                        end
                    end
                    REQ_TIMER:
                    begin
                        last_tick_next = tick_now;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_levels_reg <= '0;
            last_tick_reg  <= '0;
            started_reg    <= 1'b0;
            collecting_reg <= 1'b0;
            bytes_left_reg <= '0;
            pack_word_reg  <= '0;
            pack_fill_reg  <= '0;
        end
        else
        begin
            pin_levels_reg <= pin_levels_next;
            last_tick_reg  <= last_tick_next;
            started_reg    <= started_next;
            collecting_reg <= collecting_next;
            bytes_left_reg <= bytes_left_next;
            pack_word_reg  <= pack_word_next;
            pack_fill_reg  <= pack_fill_next;
        end
    end

`ifndef SYNTHESIS
    a_collect_needs_bytes: assert property (@(posedge clk) disable iff (!rst_n)
        collecting_reg |-> (bytes_left_reg != 8'd0 && started_reg))
        else $error("Collecting a frame with no bytes left or before start.");
    a_idle_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !collecting_reg |-> (pack_fill_reg == 2'd0 && pack_word_reg == '0))
        else $error("Packing state left over outside a payload frame.");
    a_no_push_unstarted: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> started_reg)
        else $error("Frame item produced before start.");
`endif

endmodule

// ===== sv/gef_queue.sv =====
module gef_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gef_pkg::entry_t push_entry,
    input  logic            pop,
    output logic            full,
    output logic            head_valid,
    output gef_pkg::entry_t head
);
    import gef_pkg::*;

    entry_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    always_comb
    begin
        full        = (count_reg == QCNT_W'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head        = mem_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("Queue written while full.");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && !head_valid))
        else $error("Queue read while empty.");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue count out of range.");
`endif

endmodule

// ===== sv/gef_back.sv =====
module gef_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       head_valid,
    input  gef_pkg::entry_t            head,
    output logic                       pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [gef_pkg::WORD_W-1:0] m_tdata,
    output logic                       m_tlast,
    output logic                       m_tuser
);
    import gef_pkg::*;

    logic [1:0]        idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_word_reg, out_word_next;
    logic              out_end_reg, out_end_next;
    logic              out_run_last_reg, out_run_last_next;

    logic [WORD_W-1:0] sel_word;
    logic              sel_end;
    logic              sel_fin;
    logic              load;

    always_comb
    begin
        sel_word = head.w0;
        sel_end  = head.end0;
        sel_fin  = 1'b1;
        unique case (head.kind)
            ENT_ONE:
            begin
                sel_word = head.w0;
                sel_end  = head.end0;
                sel_fin  = 1'b1;
            end
            ENT_TWO:
            begin
                if (idx_reg == 2'd0)
                begin
                    sel_word = head.w0;
                    sel_end  = head.end0;
                    sel_fin  = 1'b0;
                end
                else
                begin
                    sel_word = head.w1;
                    sel_end  = 1'b1;
                    sel_fin  = 1'b1;
                end
            end
            ENT_SYNC:
            begin
                case (idx_reg)
                    2'd0:
                    begin
                        sel_word = head.w0;
                        sel_end  = 1'b0;
                        sel_fin  = 1'b0;
                    end
                    2'd1:
                    begin
                        sel_word = head.w1;
                        sel_end  = 1'b0;
                        sel_fin  = 1'b0;
                    end
                    2'd2:
                    begin
                        sel_word = ~head.w1;
                        sel_end  = 1'b0;
                        sel_fin  = 1'b0;
                    end
                    default:
                    begin
                        sel_word = SYNC_WORD;
                        sel_end  = 1'b1;
                        sel_fin  = 1'b1;
                    end
                endcase
            end
            default:
            begin
                sel_word = head.w0;
                sel_end  = head.end0;
                sel_fin  = 1'b1;
            end
        endcase

        load = head_valid && (!out_valid_reg || m_tready);
        pop  = load && sel_fin;

        idx_next          = idx_reg;
        out_valid_next    = out_valid_reg;
        out_word_next     = out_word_reg;
        out_end_next      = out_end_reg;
        out_run_last_next = out_run_last_reg;

        if (load)
        begin
            idx_next          = sel_fin ? 2'd0 : idx_reg + 2'd1;
            out_valid_next    = 1'b1;
            out_word_next     = sel_word;
            out_end_next      = sel_end;
            out_run_last_next = sel_fin;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end

        m_tvalid = out_valid_reg;
        m_tdata  = out_word_reg;
        m_tlast  = out_end_reg;
        m_tuser  = out_run_last_reg;
    end

    always_ff @(posedge clk)
    begin
        out_word_reg     <= out_word_next;
        out_end_reg      <= out_end_next;
        out_run_last_reg <= out_run_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTHESIS
    a_idx_only_multi: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 2'd0) |-> (head_valid && head.kind != ENT_ONE))
        else $error("Word index advanced on a single-word entry.");
    a_two_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (head_valid && head.kind == ENT_TWO) |-> (idx_reg <= 2'd1))
        else $error("Word index beyond a two-word entry.");
    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (load && head.kind != ENT_ONE && sel_fin) |-> sel_end)
        else $error("Last word of a multi-word entry does not end its frame.");
`endif

endmodule

// ===== sv/gpio_event_frame_encoder_core.sv =====
// GPIO event frame encoder. Each accepted item is decoded in the cycle it arrives and
// turned into at most one queue entry; a two-entry queue feeds a word sequencer behind
// a registered output. Pin events, payload bytes and all ignored items run at one item
// per cycle while the queue is not full. A sync item produces four words and a label
// or text start with zero length produces two; the sequencer emits one word per cycle
// while m_tready stays high, so the input stalls for the extra words once the queue
// fills. Label and text payload bytes emit a word each time four bytes, counting the
// channel and length bytes that open the payload, have been packed, and on the last
// byte. The output side is taken when m_tvalid and m_tready are both high.
module gpio_event_frame_encoder_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // tick_now[31:0], channel[39:32], text_mode[40], frame_len[48:41],
    // payload_byte[56:49], zero pad[63:57].
    input  logic [63:0] s_tdata,
    // req_type[3:0].
    input  logic [3:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // frame_word[31:0].
    output logic [31:0] m_tdata,
    // frame_end.
    output logic        m_tlast,
    // run_last[0].
    output logic        m_tuser
);
    import gef_pkg::*;

    logic   accept;
    logic   push;
    entry_t push_entry;
    logic   full;
    logic   head_valid;
    entry_t head;
    logic   pop;

    assign s_tready = ~full;
    assign accept   = s_tvalid & s_tready;

    gef_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .req_type     (s_tuser),
        .tick_now     (s_tdata[31:0]),
        .channel      (s_tdata[39:32]),
        .text_mode    (s_tdata[40]),
        .frame_len    (s_tdata[48:41]),
        .payload_byte (s_tdata[56:49]),
        .push         (push),
        .entry        (push_entry)
    );

    gef_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head       (head)
    );

    gef_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ===== bench/frame_check_pkg.sv =====
package frame_check_pkg;

    import gef_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              frame_end;
        logic              run_last;
    } frame_word_t;

    class frame_scoreboard;

        frame_word_t       words_due[$];
        frame_word_t       run_words[4];
        int                run_len = 0;
        int                mismatches = 0;
        logic [WORD_W-1:0] pin_levels = '0;
        logic [WORD_W-1:0] last_tick = '0;
        logic [WORD_W-1:0] pack_word = '0;
        logic [7:0]        bytes_left = '0;
        logic [1:0]        pack_fill = '0;
        bit                started = 1'b0;
        bit                collecting = 1'b0;

        function logic [DELTA_W-1:0] take_delta(logic [WORD_W-1:0] tick);
            logic [WORD_W-1:0] diff;
            diff = tick - last_tick;
            last_tick = tick;
            return diff[DELTA_W-1:0];
        endfunction

        function void add_word(logic [WORD_W-1:0] word, logic frame_end);
            run_words[run_len] = '{word, frame_end, 1'b0};
            run_len++;
        endfunction

        function void open_payload(logic [WORD_W-1:0] header, logic [7:0] chan,
                                   logic [7:0] len);
            add_word(header, 1'b0);
            pack_word = {16'h0000, len, chan};
            pack_fill = 2'd2;
            bytes_left = len;
            collecting = (len != 8'd0);
            if (len == 8'd0)
            begin
                add_word(pack_word, 1'b1);
                pack_word = '0;
                pack_fill = '0;
            end
        endfunction

        function void encode_item(logic [3:0] req, logic [WORD_W-1:0] tick, logic [7:0] chan,
                                  logic text_mode, logic [7:0] len, logic [7:0] pbyte);
            logic [WORD_W-1:0] mask;
            logic [WORD_W-1:0] st;
            logic [7:0]        sub;
            logic [7:0]        hdr;
            run_len = 0;
            if (req == REQ_START)
            begin
                pin_levels = '0;
                last_tick = tick;
                started = 1'b1;
                collecting = 1'b0;
                bytes_left = '0;
                pack_word = '0;
                pack_fill = '0;
            end
            else if (started && (!collecting || req == REQ_PAYLOAD))
            begin
                case (req) inside
                    REQ_HIGH, REQ_LOW, REQ_TOGGLE:
                    begin
                        if (chan <= PIN_CHANNEL_MAX)
                        begin
                            mask = 32'd1 << chan[4:0];
                            if (req == REQ_HIGH ||
                                (req == REQ_TOGGLE && (pin_levels & mask) == '0))
                            begin
                                pin_levels |= mask;
                                sub = HDR_HIGH;
                            end
                            else
                            begin
                                pin_levels &= ~mask;
                                sub = HDR_LOW;
                            end
                            add_word({sub | chan, take_delta(tick)}, 1'b1);
                        end
                    end
                    REQ_SYNC:
                    begin
                        st = pin_levels & STATE_MASK;
                        add_word({HDR_SYNC, take_delta(tick)}, 1'b0);
                        add_word(st, 1'b0);
                        add_word(~st, 1'b0);
                        add_word(SYNC_WORD, 1'b1);
                    end
                    REQ_LABEL:
                    begin
                        if (chan <= RENDER_CHANNEL_MAX && len <= LABEL_LEN_MAX)
                        begin
                            open_payload({HDR_LABEL, {DELTA_W{1'b0}}}, chan, len);
                        end
                    end
                    REQ_TEXT:
                    begin
                        if (chan <= RENDER_CHANNEL_MAX)
                        begin
                            hdr = text_mode ? HDR_ASCII : HDR_HEX;
                            open_payload({hdr, take_delta(tick)}, chan, len);
                        end
                    end
                    REQ_PAYLOAD:
                    begin
                        if (collecting)
                        begin
                            pack_word |= {24'h000000, pbyte} << (8 * pack_fill);
                            pack_fill++;
                            bytes_left--;
                            if (bytes_left == 8'd0 || pack_fill == 2'd0)
                            begin
                                add_word(pack_word, bytes_left == 8'd0);
                                pack_word = '0;
                                pack_fill = '0;
                                collecting = (bytes_left != 8'd0);
                            end
                        end
                    end
                    REQ_TIMER:
                    begin
                        last_tick = tick;
                    end
                    default:
                    begin
                    end
                endcase
            end
            for (int i = 0; i < run_len; i++)
            begin
                run_words[i].run_last = (i == run_len - 1);
                words_due.push_back(run_words[i]);
            end
        endfunction

        function void check_word(frame_word_t got);
            frame_word_t want;
            if (words_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected frame word %h end %b last %b",
                             got.word, got.frame_end, got.run_last);
                end
                return;
            end
            want = words_due.pop_front();
            if (got.word !== want.word || got.frame_end !== want.frame_end ||
                got.run_last !== want.run_last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("frame word mismatch: expected %h end %b last %b, got %h end %b last %b",
                             want.word, want.frame_end, want.run_last,
                             got.word, got.frame_end, got.run_last);
                end
            end
        endfunction

        function int pending();
            return words_due.size();
        endfunction

    endclass

endpackage

// ===== bench/gpio_event_frame_encoder_core_tb.sv =====
module gpio_event_frame_encoder_core_tb;

    import gef_pkg::*;
    import frame_check_pkg::*;

    localparam int RANDOM_ITEMS = 360;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // tick_now[31:0], channel[39:32], text_mode[40], frame_len[48:41],
    // payload_byte[56:49], zero pad[63:57].
    logic [63:0] s_tdata = '0;
    // req_type[3:0].
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // frame_word[31:0].
    logic [31:0] m_tdata;
    // frame_end.
    logic        m_tlast;
    // run_last[0].
    logic        m_tuser;

    frame_scoreboard sb = new;

    logic [31:0] tick_now = '0;
    int          burst_left = 0;
    int          idle_cycles = 0;
    bit          hold_go = 1'b0;

    gpio_event_frame_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void advance_tick();
        case ($urandom_range(0, 19))
            0:       tick_now = $urandom();
            1:       tick_now += $urandom_range(32'h00ff_0000, 32'h0200_0000);
            default: tick_now += $urandom_range(0, 3000);
        endcase
    endfunction

    task automatic send_req(input logic [3:0] req, input logic [7:0] chan,
                            input logic text_mode, input logic [7:0] len,
                            input logic [7:0] pbyte);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, pbyte, len, text_mode, chan, tick_now};
        s_tuser <= req;
        advance_tick();
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_payload_frame(input bit force_text, input logic [7:0] len);
        bit is_text;
        is_text = force_text || ($urandom_range(0, 1) == 1);
        send_req(is_text ? REQ_TEXT : REQ_LABEL, rand_byte(), 1'($urandom_range(0, 1)),
                 len, rand_byte());
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                send_req(4'($urandom_range(0, 5)), rand_byte(), 1'($urandom_range(0, 1)),
                         rand_byte(), rand_byte());
            end
            if ($urandom_range(0, 149) == 0)
            begin
                send_req(REQ_START, rand_byte(), 1'($urandom_range(0, 1)),
                         rand_byte(), rand_byte());
            end
            send_req(REQ_PAYLOAD, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                     rand_byte());
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            sb.encode_item(s_tuser, s_tdata[31:0], s_tdata[39:32], s_tdata[40],
                           s_tdata[48:41], s_tdata[56:49]);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_word({m_tdata, m_tlast, m_tuser});
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : receiver
        int cyc;
        int style;
        bit held;
        cyc = 0;
        style = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_go && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            cyc++;
            if (cyc % 64 == 0)
            begin
                style = $urandom_range(0, 2);
            end
            case (style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (cyc % 5 != 0);
            endcase
        end
    end

    initial
    begin : stimulus
        int          useful;
        int          pick;
        bit          long_done;
        logic [7:0]  len;
        useful = 0;
        long_done = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Before the first start every item is ignored.
        send_req(REQ_HIGH, 8'd3, 1'b0, 8'd0, 8'd0);
        send_req(REQ_SYNC, 8'd0, 1'b0, 8'd0, 8'd0);
        tick_now = 32'hFFFF_FFF0;
        send_req(REQ_START, 8'hFF, 1'b1, 8'hFF, 8'hFF);
        send_req(REQ_HIGH, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_HIGH, 8'(PIN_CHANNEL_MAX), 1'b0, 8'd0, 8'd0);
        send_req(REQ_LOW, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_TOGGLE, 8'd5, 1'b0, 8'd0, 8'd0);
        send_req(REQ_TOGGLE, 8'd5, 1'b0, 8'd0, 8'd0);
        send_req(REQ_HIGH, 8'(PIN_CHANNEL_MAX + 1), 1'b0, 8'd0, 8'd0);
        send_req(REQ_LOW, 8'hFF, 1'b0, 8'd0, 8'd0);
        tick_now += 32'h0123_4567;
        send_req(REQ_SYNC, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_TIMER, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_LABEL, 8'hFF, 1'b0, 8'd0, 8'd0);
        send_req(REQ_TEXT, 8'h00, 1'b1, 8'd0, 8'd0);
        send_req(REQ_LABEL, 8'h12, 1'b0, LABEL_LEN_MAX + 8'd1, 8'd0);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'hAB);
        send_req(4'd15, 8'd1, 1'b0, 8'd0, 8'd0);
        send_req(REQ_TEXT, 8'hA5, 1'b0, 8'd5, 8'd0);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'hFF);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'h00);
        send_req(REQ_SYNC, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'h5A);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'hC3);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'h81);
        // A start in the middle of a label leaves it truncated.
        send_req(REQ_LABEL, 8'h3C, 1'b0, 8'd2, 8'd0);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'h77);
        send_req(REQ_START, 8'd0, 1'b0, 8'd0, 8'd0);
        send_req(REQ_PAYLOAD, 8'd0, 1'b0, 8'd0, 8'h11);

        hold_go = 1'b1;
        send_req(REQ_START, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(), rand_byte());
        while (useful < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (!long_done && useful >= 150)
            begin
                long_done = 1'b1;
                len = 8'($urandom_range(128, 200));
                send_payload_frame(1'b1, len);
                useful += len + 1;
            end
            else if (pick < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(PIN_CHANNEL_MAX + 1, 255))
                                                  : 8'($urandom_range(0, PIN_CHANNEL_MAX));
                send_req(4'($urandom_range(0, 2)), len, 1'($urandom_range(0, 1)), rand_byte(),
                         rand_byte());
                useful++;
            end
            else if (pick < 55)
            begin
                send_req(REQ_SYNC, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                         rand_byte());
                useful++;
            end
            else if (pick < 60)
            begin
                send_req(REQ_TIMER, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                         rand_byte());
                useful++;
            end
            else if (pick < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(10, 40))
                                                  : 8'($urandom_range(0, 9));
                send_payload_frame(1'b0, len);
                useful += len + 1;
            end
            else if (pick < 88)
            begin
                send_req(REQ_LABEL, rand_byte(), 1'($urandom_range(0, 1)),
                         8'($urandom_range(LABEL_LEN_MAX + 1, 255)), rand_byte());
                useful++;
            end
            else if (pick < 92)
            begin
                send_req(REQ_PAYLOAD, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                         rand_byte());
                useful++;
            end
            else if (pick < 96)
            begin
                send_req(4'($urandom_range(9, 15)), rand_byte(), 1'($urandom_range(0, 1)),
                         rand_byte(), rand_byte());
                useful++;
            end
            else if (pick < 98)
            begin
                send_req(REQ_START, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                         rand_byte());
                useful++;
            end
            else
            begin
                repeat (3)
                begin
                    send_req(REQ_SYNC, rand_byte(), 1'($urandom_range(0, 1)), rand_byte(),
                             rand_byte());
                end
                useful += 3;
            end
        end
        s_tvalid <= 1'b0;

        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== gpio_event_frame_encoder_core.f =====
sv/gef_pkg.sv
sv/gef_front.sv
sv/gef_queue.sv
sv/gef_back.sv
sv/gpio_event_frame_encoder_core.sv
bench/frame_check_pkg.sv
bench/gpio_event_frame_encoder_core_tb.sv
